/* hdl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is held.
`define PEPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define PEPI_NEVER(lbl, clk, rst_n, cond, msg) \
    `PEPI_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* hdl/pepi_pkg.sv */
// Constants and types of the per-element power integrator.
package pepi_pkg;

    // Element and bin index widths; sizes follow from them
    localparam int ELEM_W    = 2;
    localparam int BIN_W     = 10;
    localparam int MAX_ELEMS = 1 << ELEM_W;
    localparam int MAX_FREQS = 1 << BIN_W;
    localparam int ADDR_W    = ELEM_W + BIN_W;
    localparam int ACC_DEPTH = MAX_ELEMS * MAX_FREQS;

    // Field widths
    localparam int POWER_W   = 32;
    localparam int ACC_W     = 48;
    localparam int SAMP_W    = 16;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 16;
    localparam int ILEN_W    = 16;
    localparam int FCNT_W    = BIN_W + 1;

    // Configuration port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic [APB_AW-1:0] REG_INT_LEN = 3'd0;
    localparam logic [APB_AW-1:0] REG_FREQ_CNT = 3'd4;

    // Reset values of the registers
    localparam logic [ILEN_W-1:0] INT_LEN_RST  = 16'd1;
    localparam logic [FCNT_W-1:0] FREQ_CNT_RST = FCNT_W'(MAX_FREQS);

    // Item in the read-modify-write stage
    typedef struct packed {
        logic [ELEM_W-1:0]  elem;
        logic [BIN_W-1:0]   bin;
        logic [POWER_W-1:0] power;
        logic [SUM_W-1:0]   samples;
        logic               last;
        logic               dump;
        logic               fwd;
        logic [ACC_W-1:0]   fwd_val;
    } t_stage;

endpackage

/* hdl/per_element_power_integrator.sv */
// Top level of the per-element power integrator.
//
// One frequency bin is accepted per clock cycle while the output is not stalled:
// each bin makes one read-modify-write of the accumulator RAM (read at
// acceptance, add and write back from stage 1), and a bin that hits the entry
// still being written gets the new value forwarded. A result passes from stage 1
// through the output register. After reset the accumulator RAM is swept to zero,
// one entry per cycle, over all 4096 entries (MAX_ELEMS * MAX_FREQS); no item is
// accepted during the sweep, configuration writes are taken as usual.
// Packet counts and sample sums live in flip-flops, one per element.
`include "assert_macros.svh"

module per_element_power_integrator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pepi_pkg::APB_AW-1:0]   paddr,
    input  logic [pepi_pkg::APB_DW-1:0]   pwdata,
    output logic [pepi_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pepi_pkg::ELEM_W-1:0]   i_element,
    input  logic [pepi_pkg::POWER_W-1:0]  i_bin_power,
    input  logic [pepi_pkg::SAMP_W-1:0]   i_samples_in,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pepi_pkg::ELEM_W-1:0]   o_out_element,
    output logic [pepi_pkg::BIN_W-1:0]    o_out_bin,
    output logic [pepi_pkg::ACC_W-1:0]    o_integrated_power,
    output logic [pepi_pkg::SUM_W-1:0]    o_samples_total,
    output logic                          o_last_bin
);

    import pepi_pkg::*;

    // Configuration registers
    logic [ILEN_W-1:0] r_int_len;
    logic [FCNT_W-1:0] r_freq_cnt;

    // Per-element and per-packet state
    logic [CNT_W-1:0]  r_cnt [MAX_ELEMS];
    logic [SUM_W-1:0]  r_sum [MAX_ELEMS];
    logic [BIN_W-1:0]  r_bin_pos;
    logic              r_dumping;

    // Clearing sweep
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clear_addr;

    // Read-modify-write stage and output register
    logic              r_s1_valid;
    t_stage            r_s1;
    logic              r_out_valid;

    // Stage 0 signals
    logic [FCNT_W-1:0] act_bins;
    logic [BIN_W-1:0]  last_pos;
    logic [BIN_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
    logic              first;
    logic              last;
    logic [CNT_W-1:0]  n_cnt;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  n_sum;
    logic              dump_first;
    logic              dump_now;
    logic [SUM_W-1:0]  sum_now;
    logic              in_accept;

    // Stage 1 signals
    logic [ACC_W-1:0]  rd_data;
    logic [ACC_W-1:0]  acc_base;
    logic [ACC_W:0]    acc_wide;
    logic [ACC_W-1:0]  acc_sat;
    logic [ACC_W-1:0]  s1_wdata;
    logic              s1_go;

    // RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ACC_W-1:0]  ram_wdata;

    // Configuration writes and reads
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_len  <= INT_LEN_RST;
            r_freq_cnt <= FREQ_CNT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_INT_LEN:  r_int_len  <= pwdata[ILEN_W-1:0];
                REG_FREQ_CNT: r_freq_cnt <= pwdata[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_INT_LEN:  prdata = APB_DW'(r_int_len);
            REG_FREQ_CNT: prdata = APB_DW'(r_freq_cnt);
            default:      prdata = '0;
        endcase
    end

    // Active bin count: zero acts as one, large values clamp
    always_comb begin
        if (r_freq_cnt == '0) begin
            act_bins = FCNT_W'(1);
        end else if (r_freq_cnt > FCNT_W'(MAX_FREQS)) begin
            act_bins = FCNT_W'(MAX_FREQS);
        end else begin
            act_bins = r_freq_cnt;
        end
    end

    assign last_pos = BIN_W'(act_bins - FCNT_W'(1));
    assign pos      = ({1'b0, r_bin_pos} >= act_bins) ? last_pos : r_bin_pos;
    // element index is taken modulo MAX_ELEMS, which is its full width
    assign elem     = i_element;
    assign first    = (pos == '0);
    assign last     = (pos == last_pos);

    // Packet count and sample sum update at the first bin; the sum clears after a dumped last bin
    assign n_cnt      = (r_cnt[elem] == '1) ? r_cnt[elem] : r_cnt[elem] + CNT_W'(1);
    assign sum_wide   = {1'b0, r_sum[elem]} + (SUM_W + 1)'(i_samples_in);
    assign n_sum      = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign dump_first = (n_cnt >= r_int_len);
    assign dump_now   = first ? dump_first : r_dumping;
    assign sum_now    = first ? n_sum : r_sum[elem];

    // Handshake: stage 1 moves on unless its result finds the output full and stalled
    assign s1_go      = r_s1_valid && (!r_s1.dump || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !s1_go);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Stage 0 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ELEMS; k++) begin
                r_cnt[k] <= '0;
                r_sum[k] <= '0;
            end
            r_bin_pos <= '0;
            r_dumping <= 1'b0;
        end else if (in_accept) begin
            if (first) begin
                r_cnt[elem] <= dump_first ? '0 : n_cnt;
            end
            r_sum[elem] <= (dump_now && last) ? '0 : sum_now;
            r_dumping   <= last ? 1'b0 : dump_now;
            r_bin_pos   <= last ? '0 : pos + BIN_W'(1);
        end
    end

    // Load stage 1; forward the value being written to the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.elem    <= elem;
            r_s1.bin     <= pos;
            r_s1.power   <= i_bin_power;
            r_s1.samples <= sum_now;
            r_s1.last    <= last;
            r_s1.dump    <= dump_now;
            r_s1.fwd     <= r_s1_valid && (r_s1.elem == elem) && (r_s1.bin == pos);
            r_s1.fwd_val <= s1_wdata;
        end
    end

    // Stage 1: saturating accumulate; a dumped entry is written back as zero
    assign acc_base = r_s1.fwd ? r_s1.fwd_val : rd_data;
    assign acc_wide = {1'b0, acc_base} + (ACC_W + 1)'(r_s1.power);
    assign acc_sat  = acc_wide[ACC_W] ? '1 : acc_wide[ACC_W-1:0];
    assign s1_wdata = r_s1.dump ? '0 : acc_sat;

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clear_addr <= '0;
        end else if (r_clearing) begin
            r_clear_addr <= r_clear_addr + ADDR_W'(1);
            if (r_clear_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Accumulator RAM ports
    assign ram_raddr = {elem, pos};
    assign ram_we    = r_clearing || s1_go;
    assign ram_waddr = r_clearing ? r_clear_addr : {r_s1.elem, r_s1.bin};
    assign ram_wdata = r_clearing ? '0 : s1_wdata;

    pepi_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1.dump) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.dump) begin
            o_out_element      <= r_s1.elem;
            o_out_bin          <= r_s1.bin;
            o_integrated_power <= acc_sat;
            o_samples_total    <= r_s1.samples;
            o_last_bin         <= r_s1.last;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    `PEPI_NEVER(a_clear_empty, i_clk, i_rst_n,
                r_clearing && (r_s1_valid || r_out_valid),
                "item in flight during clearing sweep")
    `PEPI_ASSERT(a_clear_len, i_clk, i_rst_n,
                 $fell(r_clearing) |-> ($past(r_clear_addr) == '1),
                 "clearing sweep ended early")
    `PEPI_ASSERT(a_last_wrap, i_clk, i_rst_n,
                 (in_accept && last) |=> (r_bin_pos == '0),
                 "bin position did not wrap after last bin")
    `PEPI_NEVER(a_held_result, i_clk, i_rst_n,
                r_out_valid && i_out_stall && s1_go && r_s1.dump,
                "result overwrote a stalled result")

endmodule

/* hdl/pepi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pepi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* tb/sv/per_element_power_integrator_tb.sv */
// Self-checking testbench for the per-element power integrator.
module per_element_power_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pepi_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 780;
    localparam int CALM_ITEMS   = 640;

    // One spectrum bin as offered on the input channel
    typedef struct packed {
        logic [ELEM_W-1:0]  elem;
        logic [POWER_W-1:0] power;
        logic [SAMP_W-1:0]  samples;
    } t_bin_item;

    // One bin of a dumped spectrum
    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [BIN_W-1:0]  bin_idx;
        logic [ACC_W-1:0]  power;
        logic [SUM_W-1:0]  samples;
        logic              last_bin;
    } t_dump_bin;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ELEM_W-1:0]   i_element = '0;
    logic [POWER_W-1:0]  i_bin_power = '0;
    logic [SAMP_W-1:0]   i_samples_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [ELEM_W-1:0]   o_out_element;
    logic [BIN_W-1:0]    o_out_bin;
    logic [ACC_W-1:0]    o_integrated_power;
    logic [SUM_W-1:0]    o_samples_total;
    logic                o_last_bin;

    per_element_power_integrator u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_element          (i_element),
        .i_bin_power        (i_bin_power),
        .i_samples_in       (i_samples_in),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_element      (o_out_element),
        .o_out_bin          (o_out_bin),
        .o_integrated_power (o_integrated_power),
        .o_samples_total    (o_samples_total),
        .o_last_bin         (o_last_bin)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: accumulators, per-element counts and sample sums
    logic [ACC_W-1:0]  acc_mem [ACC_DEPTH];
    logic [CNT_W-1:0]  pkt_cnt [MAX_ELEMS];
    logic [SUM_W-1:0]  samp_sum [MAX_ELEMS];
    int                bin_pos = 0;
    logic              dumping = 1'b0;
    logic [ILEN_W-1:0] cfg_len = INT_LEN_RST;
    logic [FCNT_W-1:0] cfg_bins = FREQ_CNT_RST;

    t_bin_item bin_feed[$];
    t_dump_bin pending_dumps[$];
    t_bin_item seen_item;
    t_dump_bin want;
    int        mismatches = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    int        stall_left = 0;
    logic      hold_done = 1'b0;
    logic      squeeze = 1'b0;
    logic      calm = 1'b0;

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Integrate one accepted bin; queue a dump result when its packet is dumped
    function automatic void integrate_bin(t_bin_item it);
        int          n;
        int          p;
        int          e;
        int          idx;
        logic        is_last;
        logic [32:0] ssum;
        logic [48:0] asum;
        logic [47:0] acc;
        t_dump_bin   d;
        n = (cfg_bins == 0) ? 1 : ((cfg_bins > MAX_FREQS) ? MAX_FREQS : int'(cfg_bins));
        p = bin_pos;
        if (p >= n) p = n - 1;
        is_last = (p == n - 1);
        e = int'(it.elem) % MAX_ELEMS;

        // packet start: count it, add its samples, decide the dump
        if (p == 0) begin
            if (pkt_cnt[e] != '1) pkt_cnt[e]++;
            ssum = {1'b0, samp_sum[e]} + 33'(it.samples);
            samp_sum[e] = ssum[32] ? '1 : ssum[31:0];
            dumping = (pkt_cnt[e] >= cfg_len);
            if (dumping) pkt_cnt[e] = '0;
        end

        idx = e * MAX_FREQS + p;
        asum = {1'b0, acc_mem[idx]} + 49'(it.power);
        acc = asum[48] ? '1 : asum[47:0];
        if (dumping) begin
            d.elem = ELEM_W'(e);
            d.bin_idx = BIN_W'(p);
            d.power = acc;
            d.samples = samp_sum[e];
            d.last_bin = is_last;
            pending_dumps.push_back(d);
            acc_mem[idx] = '0;
            if (is_last) samp_sum[e] = '0;
        end else begin
            acc_mem[idx] = acc;
        end

        if (is_last) begin
            bin_pos = 0;
            dumping = 1'b0;
        end else begin
            bin_pos = p + 1;
        end
    endfunction

    // Input driver: offers queued items, with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                seen_item.elem = i_element;
                seen_item.power = i_bin_power;
                seen_item.samples = i_samples_in;
                integrate_bin(seen_item);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (bin_feed.size() != 0) begin
                    seen_item = bin_feed.pop_front();
                    i_element <= seen_item.elem;
                    i_bin_power <= seen_item.power;
                    i_samples_in <= seen_item.samples;
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 9);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: random bursts, plus one long hold-off while squeezing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            stall_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (squeeze && !hold_done && o_out_valid) begin
            i_out_stall <= 1'b1;
            hold_left <= 100;
            hold_done <= 1'b1;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: check each accepted result against the oldest expected dump
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_dumps.size() == 0) begin
                flag_mismatch($sformatf("unexpected result elem %0d bin %0d",
                                        o_out_element, o_out_bin));
            end else begin
                want = pending_dumps.pop_front();
                if (o_out_element !== want.elem)
                    flag_mismatch($sformatf("element got %0d exp %0d",
                                            o_out_element, want.elem));
                if (o_out_bin !== want.bin_idx)
                    flag_mismatch($sformatf("bin got %0d exp %0d", o_out_bin, want.bin_idx));
                if (o_integrated_power !== want.power)
                    flag_mismatch($sformatf("power got %h exp %h (bin %0d)",
                                            o_integrated_power, want.power, want.bin_idx));
                if (o_samples_total !== want.samples)
                    flag_mismatch($sformatf("samples got %0d exp %0d (bin %0d)",
                                            o_samples_total, want.samples, want.bin_idx));
                if (o_last_bin !== want.last_bin)
                    flag_mismatch($sformatf("last flag got %b exp %b (bin %0d)",
                                            o_last_bin, want.last_bin, want.bin_idx));
            end
        end
    end

    // Register write followed by a read-back
    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] stored;
        stored = (addr == REG_INT_LEN) ? (value & 32'hFFFF) : (value & 32'h7FF);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_INT_LEN) cfg_len = value[ILEN_W-1:0];
        else if (addr == REG_FREQ_CNT) cfg_bins = value[FCNT_W-1:0];
        @(posedge i_clk);
        psel <= 1'b1;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== stored)
            flag_mismatch($sformatf("register %0d read %h exp %h", addr, prdata, stored));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [APB_DW-1:0] len, logic [APB_DW-1:0] nbins);
        write_reg(REG_INT_LEN, len);
        write_reg(REG_FREQ_CNT, nbins);
        @(negedge i_clk);
    endtask

    task automatic add_item(int e, logic [POWER_W-1:0] power, logic [SAMP_W-1:0] samples);
        t_bin_item it;
        it.elem = ELEM_W'(e);
        it.power = power;
        it.samples = samples;
        bin_feed.push_back(it);
    endtask

    function automatic logic [POWER_W-1:0] rand_power();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return POWER_W'($urandom_range(0, 255));
            default: return POWER_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMP_W-1:0] rand_samples();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return SAMP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // A packet of k bins; a noisy one switches element and samples per bin
    task automatic add_packet(int k, logic noisy);
        int               e;
        logic [SAMP_W-1:0] s;
        e = $urandom_range(0, MAX_ELEMS - 1);
        s = rand_samples();
        for (int i = 0; i < k; i++) begin
            if (noisy) begin
                e = $urandom_range(0, MAX_ELEMS - 1);
                s = rand_samples();
            end
            add_item(e, rand_power(), s);
        end
    endtask

    // Wait until every item is in and every result is out, then let the pipe drain
    task automatic settle();
        while (bin_feed.size() != 0 || i_in_valid || pending_dumps.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Run watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus sequence
    initial begin
        int fed;
        int phase;
        int budget;
        int n_eff;
        int k;
        logic [APB_DW-1:0] len;
        logic [APB_DW-1:0] nbins;
        fed = 0;
        phase = 0;
        for (int i = 0; i < ACC_DEPTH; i++) acc_mem[i] = '0;
        for (int i = 0; i < MAX_ELEMS; i++) begin
            pkt_cnt[i] = '0;
            samp_sum[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-bin packets, each dumped: field extremes on every element
        configure(1, 1);
        add_item(0, '0, '0);
        add_item(1, '1, '1);
        add_item(2, '1, '0);
        add_item(3, '0, '1);
        add_item(3, 32'h1234_5678, 16'd1);
        settle();

        // two-bin packets integrated in pairs, then an element switch mid-packet
        configure(2, 2);
        add_item(1, '1, '1);
        add_item(1, 32'hAAAA_5555, 16'h5555);
        add_item(1, '1, '1);
        add_item(1, 32'h5555_AAAA, 16'hAAAA);
        add_item(2, 32'd7, 16'd9);
        add_item(3, 32'd11, 16'd13);
        settle();

        // zero length dumps every packet; zero bin count acts as one
        configure(0, 0);
        add_item(0, 32'd100, 16'd3);
        add_item(0, 32'd200, 16'd4);
        add_item(2, '1, '1);
        settle();

        // oversized bin count clamps to the maximum, longest integration
        configure(16'hFFFF, 11'h7FF);
        for (int i = 0; i < 5; i++) add_item(0, POWER_W'(i + 1) << 28, 16'd500);
        settle();

        // lower bin count and length mid-packet: next bin ends it, next start dumps
        configure(1, 3);
        add_item(0, 32'd42, 16'd1);
        add_item(0, 32'd1, 16'd2);
        add_item(0, 32'd2, 16'd2);
        add_item(0, 32'd3, 16'd2);
        settle();

        // random phases: mostly well-formed packets, some noisy ones
        while (fed < RANDOM_ITEMS) begin
            if (phase == 2) begin
                len = 0;
                nbins = 4;
            end else begin
                case ($urandom_range(0, 9))
                    0: len = 0;
                    7: len = $urandom_range(4, 8);
                    8: len = 16'hFFFF;
                    9: len = $urandom_range(0, 65535);
                    default: len = $urandom_range(1, 3);
                endcase
                case ($urandom_range(0, 9))
                    0: nbins = 0;
                    7: nbins = $urandom_range(9, 40);
                    8: nbins = MAX_FREQS;
                    9: nbins = $urandom_range(0, 2047);
                    default: nbins = $urandom_range(1, 8);
                endcase
            end
            if (fed >= CALM_ITEMS) calm <= 1'b1;
            configure(len, nbins);
            n_eff = (nbins == 0) ? 1 : ((nbins > MAX_FREQS) ? MAX_FREQS : int'(nbins));
            budget = (phase == 2) ? 120 : $urandom_range(30, 70);
            if (phase == 2) squeeze <= 1'b1;
            fed += budget;
            while (budget > 0) begin
                k = (n_eff < budget) ? n_eff : budget;
                add_packet(k, $urandom_range(0, 6) == 0);
                budget -= k;
            end
            settle();
            squeeze <= 1'b0;
            phase++;
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* per_element_power_integrator.f */
+incdir+hdl
hdl/pepi_pkg.sv
hdl/pepi_ram.sv
hdl/per_element_power_integrator.sv
tb/sv/per_element_power_integrator_tb.sv
